### rtl/plc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg: shared types and codes of the positional list store
// Request and result beat layouts, request codes, status codes and the
// command that the controller broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned CNT_W   = 6;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_DUMP   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_APPEND,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_ROTATE
	} cmd_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] entry_value;
		logic [1:0]               status;
		logic [CNT_W-1:0]         entry_count;
		logic                     last;
	} rsp_t;

endpackage

### rtl/plc_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_chan_if: valid/ready channel
// Carries one payload beat per cycle in which valid and ready are both high.
// ----------------------------------------------------------------------------
interface plc_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/plc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_cell: one slot of the list
// Holds the entry at position IDX; on each broadcast command it keeps its
// value, loads the shared data bus, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module plc_cell #(
	parameter int unsigned CW  = 6,
	parameter int unsigned IDX = 0
) (
	input  logic                              clk,
	input  plc_pkg::cmd_t                     cmd,
	input  logic [CW-1:0]                     pos,
	input  logic [CW-1:0]                     count,
	input  logic signed [plc_pkg::DATA_W-1:0] load_data,
	input  logic signed [plc_pkg::DATA_W-1:0] left,
	input  logic signed [plc_pkg::DATA_W-1:0] right,
	output logic signed [plc_pkg::DATA_W-1:0] value
);

	localparam logic [CW:0] MY_POS  = (CW+1)'(IDX);
	localparam logic [CW:0] MY_NEXT = (CW+1)'(IDX + 1);

	logic [CW:0] pos_x;
	logic [CW:0] cnt_x;
	logic        do_load;
	logic        do_left;
	logic        do_right;
	logic signed [plc_pkg::DATA_W-1:0] value_q;

	assign pos_x = {1'b0, pos};
	assign cnt_x = {1'b0, count};

	always_comb begin
		do_load  = 1'b0;
		do_left  = 1'b0;
		do_right = 1'b0;
		case (cmd)
			plc_pkg::CMD_APPEND: begin
				do_load = (MY_POS == cnt_x);
			end
			plc_pkg::CMD_INSERT: begin
				do_load = (MY_POS == pos_x);
				do_left = (MY_POS > pos_x) && (MY_POS <= cnt_x);
			end
			plc_pkg::CMD_REMOVE: begin
				do_right = (MY_POS >= pos_x) && (MY_NEXT < cnt_x);
			end
			plc_pkg::CMD_ROTATE: begin
				// head wraps around to the last occupied slot
				do_right = (MY_NEXT < cnt_x);
				do_load  = (MY_NEXT == cnt_x);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			value_q <= load_data;
		end else if (do_left) begin
			value_q <= left;
		end else if (do_right) begin
			value_q <= right;
		end
	end

	assign value = value_q;

endmodule

### rtl/positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list with positional insert/remove
// Row of DEPTH cells that shift in place; a controller decodes requests.
// ----------------------------------------------------------------------------
// Append, insert and remove each take one request beat and give one result
// beat; the row of cells shifts the affected entries in the cycle the request is
// accepted, so such requests go at one per cycle while the result side keeps
// up. A dump of a non-empty list gives one beat per entry, reading the head
// cell while the row rotates by one slot per beat; no request is taken until
// its last beat is loaded. Every result carries the entry count after the
// request, masked to six bits.
module positional_list_store #(
	parameter int unsigned DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	plc_chan_if.sink    req,
	plc_chan_if.source  rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic {S_IDLE, S_DUMP} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  dump_idx_q;
	logic           out_vld_q;
	plc_pkg::rsp_t  out_q;

	plc_pkg::req_t  rq;
	logic           out_free;
	logic           in_fire;
	logic           pos_ok;
	logic           full;
	logic           empty;
	logic           dump_step;
	logic           dump_last;
	logic           load_out;
	plc_pkg::cmd_t  cmd;
	logic [1:0]     status;
	logic [CW-1:0]  count_d;
	logic [CW+5:0]  count_ext;
	logic           start_dump;
	logic [CW-1:0]  pos_idx;
	logic signed [plc_pkg::DATA_W-1:0] load_data;
	logic signed [plc_pkg::DATA_W-1:0] cell_val [DEPTH];

	assign rq        = req.data;
	assign out_free  = !out_vld_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign in_fire   = req.valid && req.ready;
	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign pos_ok    = !rq.position[31] &&
	                   ({1'b0, rq.position[30:0]} < 32'(count_q));
	assign pos_idx   = rq.position[CW-1:0];
	assign dump_step = (state_q == S_DUMP) && out_free;
	assign dump_last = (dump_idx_q + CW'(1)) == count_q;
	assign load_data = (state_q == S_DUMP) ? cell_val[0] : rq.value;
	assign load_out  = (in_fire && !start_dump) || dump_step;

	// decode the request into a cell command and a status; rotate on each dump step
	always_comb begin
		cmd        = plc_pkg::CMD_NONE;
		status     = plc_pkg::ST_OK;
		start_dump = 1'b0;
		if (in_fire) begin
			unique case (rq.req_type)
				plc_pkg::REQ_APPEND: begin
					if (full) begin
						status = plc_pkg::ST_FULL;
					end else begin
						cmd = plc_pkg::CMD_APPEND;
					end
				end
				plc_pkg::REQ_INSERT: begin
					if (empty) begin
						cmd = plc_pkg::CMD_APPEND;
					end else if (!pos_ok) begin
						status = plc_pkg::ST_BADPOS;
					end else if (full) begin
						status = plc_pkg::ST_FULL;
					end else begin
						cmd = plc_pkg::CMD_INSERT;
					end
				end
				plc_pkg::REQ_REMOVE: begin
					if (empty) begin
						status = plc_pkg::ST_EMPTY;
					end else if (!pos_ok) begin
						status = plc_pkg::ST_BADPOS;
					end else begin
						cmd = plc_pkg::CMD_REMOVE;
					end
				end
				plc_pkg::REQ_DUMP: begin
					if (empty) begin
						status = plc_pkg::ST_EMPTY;
					end else begin
						start_dump = 1'b1;
					end
				end
			endcase
		end else if (dump_step) begin
			cmd = plc_pkg::CMD_ROTATE;
		end
	end

	always_comb begin
		count_d = count_q;
		case (cmd)
			plc_pkg::CMD_APPEND, plc_pkg::CMD_INSERT: count_d = count_q + CW'(1);
			plc_pkg::CMD_REMOVE:                      count_d = count_q - CW'(1);
			default:                                  count_d = count_q;
		endcase
	end

	assign count_ext = {6'b0, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			dump_idx_q <= '0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			count_q <= count_d;
			// a new beat wins over the one leaving in this cycle
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && start_dump) begin
						state_q    <= S_DUMP;
						dump_idx_q <= '0;
					end else if (in_fire) begin
						out_q.entry_value <= '0;
						out_q.status      <= status;
						out_q.entry_count <= count_ext[5:0];
						out_q.last        <= 1'b1;
					end
				end
				S_DUMP: begin
					if (dump_step) begin
						out_q.entry_value <= cell_val[0];
						out_q.status      <= plc_pkg::ST_OK;
						out_q.entry_count <= count_ext[5:0];
						out_q.last        <= dump_last;
						dump_idx_q        <= dump_idx_q + CW'(1);
						if (dump_last) begin
							state_q <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [plc_pkg::DATA_W-1:0] left_v;
		logic signed [plc_pkg::DATA_W-1:0] right_v;
		if (i == 0) begin : g_head
			assign left_v = '0;
		end else begin : g_body
			assign left_v = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_v = '0;
		end else begin : g_inner
			assign right_v = cell_val[i+1];
		end
		plc_cell #(
			.CW  (CW),
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.pos       (pos_idx),
			.count     (count_q),
			.load_data (load_data),
			.left      (left_v),
			.right     (right_v),
			.value     (cell_val[i])
		);
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count exceeds depth");

	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> dump_idx_q < count_q)
		else $error("dump index past last entry");

	a_no_req_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> !req.ready)
		else $error("request taken during dump");

	a_dump_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |=> count_q == $past(count_q))
		else $error("count changed during dump");

	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		dump_step && dump_last |=> state_q == S_IDLE && out_vld_q && rsp.data.last)
		else $error("dump did not end on last beat");
`endif

endmodule

### test/tb_positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_store: self-checking bench for the positional list store
// Drives append, insert, remove and dump requests under varied idle and stall
// patterns. A shadow list predicts every result beat, and each beat is checked
// field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_positional_list_store;
	import plc_pkg::*;

	localparam int LIST_DEPTH = 32;

	// Shadow copy of the list with the queue of result beats still awaited
	class list_shadow;
		logic signed [DATA_W-1:0] held[$];
		rsp_t                     awaited[$];
		int                       errors;

		function new();
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void await_beat(logic signed [DATA_W-1:0] val, logic [1:0] st, logic fin);
			rsp_t beat;
			int   n;
			n = held.size();
			beat.entry_value = val;
			beat.status      = st;
			beat.entry_count = n[CNT_W-1:0];
			beat.last        = fin;
			awaited.push_back(beat);
		endfunction

		function void take_request(req_t r);
			int pos;
			int n;
			pos = r.position;
			n = held.size();
			case (r.req_type)
			REQ_APPEND: begin
				if (n >= LIST_DEPTH) begin
					await_beat('0, ST_FULL, 1'b1);
				end else begin
					held.push_back(r.value);
					await_beat('0, ST_OK, 1'b1);
				end
			end
			REQ_INSERT: begin
				// an empty list takes the value whatever the position
				if (n == 0) begin
					held.push_back(r.value);
					await_beat('0, ST_OK, 1'b1);
				end else if (pos < 0 || pos >= n) begin
					await_beat('0, ST_BADPOS, 1'b1);
				end else if (n >= LIST_DEPTH) begin
					await_beat('0, ST_FULL, 1'b1);
				end else begin
					held.insert(pos, r.value);
					await_beat('0, ST_OK, 1'b1);
				end
			end
			REQ_REMOVE: begin
				if (n == 0) begin
					await_beat('0, ST_EMPTY, 1'b1);
				end else if (pos < 0 || pos >= n) begin
					await_beat('0, ST_BADPOS, 1'b1);
				end else begin
					held.delete(pos);
					await_beat('0, ST_OK, 1'b1);
				end
			end
			default: begin
				if (n == 0) begin
					await_beat('0, ST_EMPTY, 1'b1);
				end else begin
					foreach (held[i])
						await_beat(held[i], ST_OK, i == n - 1);
				end
			end
			endcase
		endfunction

		function void match_result(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$error("result beat with nothing awaited: entry_value %0d status %0d count %0d",
					got.entry_value, got.status, got.entry_count);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.entry_value !== want.entry_value) begin
				$error("entry_value: expected %0d, actual %0d", want.entry_value, got.entry_value);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_stall_pct;
	logic rx_hold;
	event hold_go;

	list_shadow shadow = new();

	plc_chan_if #(.T(req_t)) req_ch ();
	plc_chan_if #(.T(rsp_t)) rsp_ch ();

	positional_list_store #(
		.DEPTH(LIST_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		rx_hold = 1'b0;
		forever begin
			@(hold_go);
			rx_hold <= 1'b1;
			repeat (300) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// Sample both handshakes in one place so ordering within the edge is fixed
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				shadow.take_request(req_ch.data);
			if (rsp_ch.valid && rsp_ch.ready)
				shadow.match_result(rsp_ch.data);
		end
	end

	task automatic send_req(logic [1:0] kind, logic signed [DATA_W-1:0] pos,
			logic signed [DATA_W-1:0] val);
		req_t r;
		int   gap;
		r.req_type = kind;
		r.position = pos;
		r.value    = val;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
	endtask

	// Step past the edge of the last accepted beat so the shadow has seen it
	task automatic wait_drained();
		@(posedge clk);
		while (shadow.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return 32'sh8000_0000;
		if (roll < 20)
			return 32'sh7FFF_FFFF;
		if (roll < 25)
			return '0;
		return $urandom;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_position(int n_held);
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return (n_held > 0) ? $urandom_range(n_held - 1) : 0;
		if (roll < 80)
			return n_held;
		if (roll < 88)
			return -$urandom_range(4, 1);
		return $urandom;
	endfunction

	// Fill to full and past it, dump, then wander the list size up and down
	task automatic run_phase(int n_items, bit with_hold);
		int         n_held;
		int         roll;
		bit         grow;
		logic [1:0] kind;
		if (with_hold)
			-> hold_go;
		repeat (36) begin
			n_held = shadow.held.size();
			if ($urandom_range(1))
				send_req(REQ_APPEND, $urandom, pick_value());
			else
				send_req(REQ_INSERT, $urandom_range(n_held), pick_value());
		end
		send_req(REQ_DUMP, $urandom, $urandom);
		grow = 1'b1;
		for (int k = 0; k < n_items; k++) begin
			if (k % 25 == 0)
				grow = !grow;
			n_held = shadow.held.size();
			roll = $urandom_range(99);
			if (roll < 8)
				kind = REQ_DUMP;
			else if (roll < (grow ? 48 : 25))
				kind = REQ_APPEND;
			else if (roll < (grow ? 83 : 43))
				kind = REQ_INSERT;
			else
				kind = REQ_REMOVE;
			send_req(kind, pick_position(n_held), pick_value());
		end
		req_ch.valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		int tx_pct[4];
		int rx_pct[4];
		tx_pct       = '{0, 77, 0, 27};
		rx_pct       = '{0, 0, 77, 27};
		arst_n       = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list cases, boundary positions and extreme values
		send_req(REQ_REMOVE, 0, 0);
		send_req(REQ_DUMP, 0, 0);
		send_req(REQ_INSERT, -5, 32'sh7FFF_FFFF);
		send_req(REQ_APPEND, 0, 32'sh8000_0000);
		send_req(REQ_APPEND, 32'sh7FFF_FFFF, 0);
		send_req(REQ_INSERT, 0, -1);
		send_req(REQ_INSERT, 3, 12345);
		send_req(REQ_INSERT, 5, 77);
		send_req(REQ_INSERT, 32'sh7FFF_FFFF, 78);
		send_req(REQ_INSERT, 32'sh8000_0000, 79);
		send_req(REQ_REMOVE, -1, 0);
		send_req(REQ_REMOVE, 5, 0);
		send_req(REQ_DUMP, 0, 0);
		send_req(REQ_REMOVE, 4, 0);
		send_req(REQ_REMOVE, 0, 0);
		send_req(REQ_REMOVE, 1, 0);
		send_req(REQ_DUMP, -1, -1);
		send_req(REQ_REMOVE, 0, 0);
		send_req(REQ_REMOVE, 0, 0);
		send_req(REQ_REMOVE, 0, 0);
		send_req(REQ_INSERT, 32'sh7FFF_FFFF, -2);
		send_req(REQ_REMOVE, 32'sh8000_0000, 0);
		send_req(REQ_REMOVE, 0, 0);
		req_ch.valid <= 1'b0;
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = tx_pct[ph];
			rx_stall_pct = rx_pct[ph];
			run_phase(75, ph == 0);
		end

		repeat (40) @(posedge clk);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
